// File: rtl/core/ddo_pkg.sv
// shared types, constants and tables for the differential drive odometry block
`default_nettype none
package ddo_pkg;

   // cordic step count, capped by the length of the arctangent table
   localparam int CORDIC_STEPS = 16;
   localparam int CORDIC_N     = (CORDIC_STEPS < 30) ? CORDIC_STEPS : 30;
   localparam int CORDIC_CW    = (CORDIC_N > 1) ? $clog2(CORDIC_N) : 1;

   // shared multiply / divide unit
   localparam int MUL_STEPS = 32;
   localparam int DIV_STEPS = 64;
   localparam int ALU_CW    = $clog2(DIV_STEPS);

   localparam logic [31:0] TWO_PI_Q29      = 32'd3373259426;
   localparam logic [33:0] CORDIC_GAIN_Q30 = 34'd652032874;

   // register indexes
   localparam logic [1:0] CSR_PPR    = 2'd0;
   localparam logic [1:0] CSR_RADIUS = 2'd1;
   localparam logic [1:0] CSR_BASE   = 2'd2;

   localparam logic [15:0] PPR_RESET    = 16'd20;
   localparam logic [15:0] RADIUS_RESET = 16'd2163;
   localparam logic [19:0] BASE_RESET   = 20'd9830;

   typedef enum logic {
      ALU_MUL,
      ALU_DIV
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
      logic [39:0] opa;   // multiplicand, or divisor in the low 37 bits
      logic [63:0] opb;   // multiplier in the low 32 bits, or dividend
   } alu_req_type;

   typedef struct packed {
      logic        done;
      logic [40:0] hi;    // product high part, or remainder
      logic [63:0] lo;    // product low part in [63:32], or quotient
   } alu_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_LMR,
      ST_LMP,
      ST_LDV,
      ST_RMR,
      ST_RMP,
      ST_RDV,
      ST_DEN,
      ST_DMR,
      ST_HDV,
      ST_ANG,
      ST_COR,
      ST_CFIN,
      ST_MX,
      ST_SX,
      ST_MY,
      ST_SY,
      ST_OUT
   } state_type;

   // arctangent of 2^-i as a binary angle
   function automatic logic [31:0] ddo_atan(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'h20000000;
         5'd1:  v = 32'h12E4051E;
         5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;
         5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;
         5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2F;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2FA;
         5'd15: v = 32'h0000517D;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A30;
         5'd19: v = 32'h00000518;
         5'd20: v = 32'h0000028C;
         5'd21: v = 32'h00000146;
         5'd22: v = 32'h000000A3;
         5'd23: v = 32'h00000051;
         5'd24: v = 32'h00000029;
         5'd25: v = 32'h00000014;
         5'd26: v = 32'h0000000A;
         5'd27: v = 32'h00000005;
         5'd28: v = 32'h00000003;
         5'd29: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/ddo_alu.sv
// shared iterative unit: shift-add multiply and restoring divide
`default_nettype none
module ddo_alu (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ddo_pkg::alu_req_type alu_req,
   output ddo_pkg::alu_rsp_type    alu_rsp
);
   import ddo_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   alu_op_type        op_ff, op_in;
   logic [39:0]       opa_ff, opa_in;
   logic [40:0]       acc_ff, acc_in;
   logic [63:0]       sh_ff, sh_in;
   logic [ALU_CW-1:0] cnt_ff, cnt_in;

   logic [37:0] div_t;
   logic [40:0] add_x, add_y;
   logic [41:0] sum;
   logic        last;

   // one adder: accumulate for multiply, trial subtract for divide
   always_comb begin
      div_t = {acc_ff[36:0], sh_ff[63]};
      if (op_ff == ALU_MUL) begin
         add_x = acc_ff;
         add_y = sh_ff[0] ? {1'b0, opa_ff} : 41'd0;
      end else begin
         add_x = {3'b000, div_t};
         add_y = ~{4'b0000, opa_ff[36:0]};
      end
      sum = {1'b0, add_x} + {1'b0, add_y} + {41'd0, (op_ff == ALU_DIV)};
      if (op_ff == ALU_MUL) begin
         last = (cnt_ff == ALU_CW'(MUL_STEPS - 1));
      end else begin
         last = (cnt_ff == ALU_CW'(DIV_STEPS - 1));
      end
   end

   // next register values
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      opa_in  = opa_ff;
      acc_in  = acc_ff;
      sh_in   = sh_ff;
      cnt_in  = cnt_ff;
      if (alu_req.start) begin
         busy_in = 1'b1;
         op_in   = alu_req.op;
         opa_in  = alu_req.opa;
         acc_in  = 41'd0;
         sh_in   = (alu_req.op == ALU_MUL) ? {32'd0, alu_req.opb[31:0]} : alu_req.opb;
         cnt_in  = '0;
      end else if (busy_ff) begin
         if (op_ff == ALU_MUL) begin
            acc_in = sum[41:1];
            sh_in  = {sum[0], sh_ff[63:1]};
         end else begin
            acc_in = {4'b0000, sum[41] ? sum[36:0] : div_t[36:0]};
            sh_in  = {sh_ff[62:0], sum[41]};
         end
         cnt_in = cnt_ff + ALU_CW'(1);
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      opa_ff <= opa_in;
      acc_ff <= acc_in;
      sh_ff  <= sh_in;
   end

   assign alu_rsp.done = done_ff;
   assign alu_rsp.hi   = acc_ff;
   assign alu_rsp.lo   = sh_ff;

endmodule
`default_nettype wire

// File: rtl/core/differential_drive_odometry.sv
// top level: odometry sequencer, cordic, pose accumulators and register port
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | left_pulses, right_pulses
//  rsp     | out       | rsp_valid/rsp_ready  | pos_x, pos_y, heading, saturated
//  csr     | in        | csr_valid/csr_ready  | csr_index, csr_wdata
//
// one beat runs eight multiplies and three divides on the shared shift-add /
// restoring unit, plus CORDIC_STEPS cordic steps and the ANG, CFIN, SX, SY
// and OUT steps
// reset clears pose and heading and loads the register defaults
// a result waiting on rsp does not block the next req beat; the sequencer
// holds before its output load until the rsp register is free
`default_nettype none
module differential_drive_odometry (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic signed [15:0] req_left_pulses,
   input  wire logic signed [15:0] req_right_pulses,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic [31:0]      rsp_heading,
   output logic             rsp_saturated,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [19:0] csr_wdata
);
   import ddo_pkg::*;

   state_type state_ff, state_in;

   logic [15:0] ppr_ff, radius_ff;
   logic [19:0] base_ff;
   logic signed [31:0] x_acc_ff, y_acc_ff;
   logic [31:0] heading_ff;

   logic [15:0] mag_l_ff, mag_r_ff, dm_ff;
   logic        neg_l_ff, neg_r_ff, dneg_ff;
   logic [63:0] tmp_ff;
   logic signed [35:0] dl_ff, dr_ff, dc_ff;
   logic [35:0] den_ff;
   logic [31:0] full_ff, half_ff;
   logic signed [33:0] cx_ff, cy_ff, cz_ff;
   logic        flip_ff;
   logic [CORDIC_CW-1:0] ccnt_ff;
   logic signed [31:0] c_ff, s_ff;
   logic signed [45:0] dd_ff;
   logic        clip_ff;
   logic        issued_ff;

   logic        rsp_valid_ff;
   logic signed [31:0] rsp_x_ff, rsp_y_ff;
   logic [31:0] rsp_h_ff;
   logic        rsp_sat_ff;

   alu_req_type alu_req;
   alu_rsp_type alu_rsp;
   logic        op_state;
   logic        out_free;

   ddo_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   // effective divisors: zero reads as one
   logic [15:0] ppr_eff;
   logic [19:0] base_eff;
   assign ppr_eff  = (ppr_ff == 16'd0) ? 16'd1 : ppr_ff;
   assign base_eff = (base_ff == 20'd0) ? 20'd1 : base_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_LMR;
         ST_LMR:  if (alu_rsp.done) state_in = ST_LMP;
         ST_LMP:  if (alu_rsp.done) state_in = ST_LDV;
         ST_LDV:  if (alu_rsp.done) state_in = ST_RMR;
         ST_RMR:  if (alu_rsp.done) state_in = ST_RMP;
         ST_RMP:  if (alu_rsp.done) state_in = ST_RDV;
         ST_RDV:  if (alu_rsp.done) state_in = ST_DEN;
         ST_DEN:  if (alu_rsp.done) state_in = ST_DMR;
         ST_DMR:  if (alu_rsp.done) state_in = ST_HDV;
         ST_HDV:  if (alu_rsp.done) state_in = ST_ANG;
         ST_ANG:  state_in = ST_COR;
         ST_COR:  if (ccnt_ff == CORDIC_CW'(CORDIC_N - 1)) state_in = ST_CFIN;
         ST_CFIN: state_in = ST_MX;
         ST_MX:   if (alu_rsp.done) state_in = ST_SX;
         ST_SX:   state_in = ST_MY;
         ST_MY:   if (alu_rsp.done) state_in = ST_SY;
         ST_SY:   state_in = ST_OUT;
         ST_OUT:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // magnitudes for the pose multiplies
   logic [35:0] dc_mag;
   logic [31:0] c_mag, s_mag;
   assign dc_mag = dc_ff[35] ? 36'(-dc_ff) : 36'(dc_ff);
   assign c_mag  = c_ff[31] ? 32'(-c_ff) : 32'(c_ff);
   assign s_mag  = s_ff[31] ? 32'(-s_ff) : 32'(s_ff);

   // sequencer outputs: handshakes and shared unit requests
   always_comb begin
      req_ready   = 1'b0;
      op_state    = 1'b0;
      alu_req.op  = ALU_MUL;
      alu_req.opa = 40'd0;
      alu_req.opb = 64'd0;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_LMR: begin
            op_state    = 1'b1;
            alu_req.opa = {24'd0, mag_l_ff};
            alu_req.opb = {48'd0, radius_ff};
         end
         ST_RMR: begin
            op_state    = 1'b1;
            alu_req.opa = {24'd0, mag_r_ff};
            alu_req.opb = {48'd0, radius_ff};
         end
         ST_LMP, ST_RMP: begin
            op_state    = 1'b1;
            alu_req.opa = tmp_ff[39:0];
            alu_req.opb = {32'd0, TWO_PI_Q29};
         end
         ST_LDV, ST_RDV: begin
            op_state    = 1'b1;
            alu_req.op  = ALU_DIV;
            alu_req.opa = {24'd0, ppr_eff};
            alu_req.opb = tmp_ff;
         end
         ST_DEN: begin
            op_state    = 1'b1;
            alu_req.opa = {24'd0, ppr_eff};
            alu_req.opb = {44'd0, base_eff};
         end
         ST_DMR: begin
            op_state    = 1'b1;
            alu_req.opa = {24'd0, dm_ff};
            alu_req.opb = {48'd0, radius_ff};
         end
         ST_HDV: begin
            op_state    = 1'b1;
            alu_req.op  = ALU_DIV;
            alu_req.opa = {4'd0, den_ff};
            alu_req.opb = {tmp_ff[31:0], 32'd0};
         end
         ST_MX: begin
            op_state    = 1'b1;
            alu_req.opa = {4'd0, dc_mag};
            alu_req.opb = {32'd0, c_mag};
         end
         ST_MY: begin
            op_state    = 1'b1;
            alu_req.opa = {4'd0, dc_mag};
            alu_req.opb = {32'd0, s_mag};
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
      alu_req.start = op_state && !issued_ff;
   end

   assign csr_ready = 1'b1;

   // wheel distance from the divide quotient, rounded and signed
   logic [36:0] dist_up;
   logic [35:0] dist_mag;
   assign dist_up  = {1'b0, alu_rsp.lo[63:28]} + 37'd1;
   assign dist_mag = dist_up[36:1];

   // heading quotient rounding
   logic [63:0] hq;
   logic [36:0] hr;
   logic        round_full;
   assign hq         = alu_rsp.lo;
   assign hr         = alu_rsp.hi[36:0];
   assign round_full = {hr, 1'b0} >= {2'b00, den_ff};

   // mid-interval angle, fold and centre distance
   logic [31:0] mid, turn;
   logic        flip;
   logic [36:0] dsum;
   assign mid  = dneg_ff ? heading_ff - half_ff : heading_ff + half_ff;
   assign turn = mid + 32'h4000_0000;
   assign flip = turn[31];
   assign dsum = 37'(dl_ff) + 37'(dr_ff) + 37'sd1;

   // cordic step
   logic signed [33:0] xs, ys, cxn, cyn;
   logic [33:0] atan_z;
   assign xs     = cx_ff >>> ccnt_ff;
   assign ys     = cy_ff >>> ccnt_ff;
   assign atan_z = {2'b00, ddo_atan(5'(ccnt_ff))};
   assign cxn    = flip_ff ? -cx_ff : cx_ff;
   assign cyn    = flip_ff ? -cy_ff : cy_ff;

   // rounded product scale, one add for either sign
   logic [73:0] prod, wsum;
   logic        pneg;
   assign prod = {1'b0, alu_rsp.hi, alu_rsp.lo[63:32]};
   assign pneg = dc_ff[35] ^ ((state_ff == ST_MX) ? c_ff[31] : s_ff[31]);
   assign wsum = pneg ? (~prod + 74'd134217729) : (prod + 74'd134217728);

   // saturating pose add
   logic signed [46:0] psum;
   logic        povf;
   logic signed [31:0] psat;
   assign psum = ((state_ff == ST_SX) ? 47'(x_acc_ff) : 47'(y_acc_ff)) + 47'(dd_ff);
   assign povf = (psum[46:31] != {16{psum[46]}});
   assign psat = povf ? (psum[46] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : psum[31:0];

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ppr_ff       <= PPR_RESET;
         radius_ff    <= RADIUS_RESET;
         base_ff      <= BASE_RESET;
         x_acc_ff     <= 32'sd0;
         y_acc_ff     <= 32'sd0;
         heading_ff   <= 32'd0;
         ccnt_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (alu_req.start) begin
            issued_ff <= 1'b1;
         end else if (alu_rsp.done) begin
            issued_ff <= 1'b0;
         end
         // result register
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         // register writes
         if (csr_valid) begin
            case (csr_index)
               CSR_PPR:    ppr_ff    <= csr_wdata[15:0];
               CSR_RADIUS: radius_ff <= csr_wdata[15:0];
               CSR_BASE:   base_ff   <= csr_wdata;
               default:    ppr_ff    <= ppr_ff;
            endcase
         end
         if (state_ff == ST_ANG) begin
            heading_ff <= dneg_ff ? heading_ff - full_ff : heading_ff + full_ff;
         end
         if (state_ff == ST_SX) x_acc_ff <= psat;
         if (state_ff == ST_SY) y_acc_ff <= psat;
         // cordic step counter
         if (state_ff == ST_ANG) begin
            ccnt_ff <= '0;
         end else if (state_ff == ST_COR) begin
            ccnt_ff <= ccnt_ff + CORDIC_CW'(1);
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mag_l_ff <= req_left_pulses[15] ? 16'(-req_left_pulses) : req_left_pulses;
               mag_r_ff <= req_right_pulses[15] ? 16'(-req_right_pulses) : req_right_pulses;
               neg_l_ff <= req_left_pulses[15];
               neg_r_ff <= req_right_pulses[15];
               dneg_ff  <= (req_right_pulses < req_left_pulses);
               dm_ff    <= (req_right_pulses < req_left_pulses)
                  ? 16'(17'(req_left_pulses) - 17'(req_right_pulses))
                  : 16'(17'(req_right_pulses) - 17'(req_left_pulses));
               clip_ff  <= 1'b0;
            end
         end
         ST_LMR, ST_LMP, ST_RMR, ST_RMP, ST_DMR: begin
            if (alu_rsp.done) tmp_ff <= {alu_rsp.hi[31:0], alu_rsp.lo[63:32]};
         end
         ST_LDV: begin
            if (alu_rsp.done) dl_ff <= neg_l_ff ? -$signed(dist_mag) : $signed(dist_mag);
         end
         ST_RDV: begin
            if (alu_rsp.done) dr_ff <= neg_r_ff ? -$signed(dist_mag) : $signed(dist_mag);
         end
         ST_DEN: begin
            if (alu_rsp.done) den_ff <= {alu_rsp.hi[3:0], alu_rsp.lo[63:32]};
         end
         ST_HDV: begin
            if (alu_rsp.done) begin
               full_ff <= hq[31:0] + {31'd0, round_full};
               half_ff <= hq[32:1] + {31'd0, hq[0]};
            end
         end
         ST_ANG: begin
            dc_ff   <= dsum[36:1];
            flip_ff <= flip;
            cz_ff   <= 34'($signed({mid[31] ^ flip, mid[30:0]}));
            cx_ff   <= CORDIC_GAIN_Q30;
            cy_ff   <= 34'sd0;
         end
         ST_COR: begin
            if (!cz_ff[33]) begin
               cx_ff <= cx_ff - ys;
               cy_ff <= cy_ff + xs;
               cz_ff <= cz_ff - $signed(atan_z);
            end else begin
               cx_ff <= cx_ff + ys;
               cy_ff <= cy_ff - xs;
               cz_ff <= cz_ff + $signed(atan_z);
            end
         end
         ST_CFIN: begin
            c_ff <= 32'((cxn + 34'sd2) >>> 2);
            s_ff <= 32'((cyn + 34'sd2) >>> 2);
         end
         ST_MX, ST_MY: begin
            if (alu_rsp.done) dd_ff <= wsum[73:28];
         end
         ST_SX, ST_SY: begin
            if (povf) clip_ff <= 1'b1;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_x_ff   <= x_acc_ff;
               rsp_y_ff   <= y_acc_ff;
               rsp_h_ff   <= heading_ff;
               rsp_sat_ff <= clip_ff;
            end
         end
         default: begin
            tmp_ff <= tmp_ff;
         end
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pos_x     = rsp_x_ff;
   assign rsp_pos_y     = rsp_y_ff;
   assign rsp_heading   = rsp_h_ff;
   assign rsp_saturated = rsp_sat_ff;

endmodule
`default_nettype wire

// File: rtl/core/ddo_checker.sv
// port-level checks for the odometry block, bound to the top level
`default_nettype none
module ddo_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_pos_x,
   input wire logic [31:0] rsp_pos_y,
   input wire logic [31:0] rsp_heading,
   input wire logic        rsp_saturated
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pos_x) &&
      $stable(rsp_pos_y) && $stable(rsp_heading) && $stable(rsp_saturated))
      else $error("rsp beat changed while stalled");

   // an accepted request keeps the block busy next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req ready right after an accepted beat");

   // no result right after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // a clip flag means a coordinate sits at a range limit
   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
      rsp_pos_x == 32'h7FFF_FFFF || rsp_pos_x == 32'h8000_0000 ||
      rsp_pos_y == 32'h7FFF_FFFF || rsp_pos_y == 32'h8000_0000)
      else $error("saturated flag without a clipped coordinate");

endmodule

bind differential_drive_odometry ddo_checker u_ddo_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_pos_x     (rsp_pos_x),
   .rsp_pos_y     (rsp_pos_y),
   .rsp_heading   (rsp_heading),
   .rsp_saturated (rsp_saturated)
);
`default_nettype wire
